FILE: rtl/spq_pkg.sv
package spq_pkg;

    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned OUT_PAY_W = 32;
    localparam int unsigned REM_W    = 5;

    typedef enum logic [1:0] {
        ST_ADDED  = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic {
        ACT_ADD = 1'b0,
        ACT_POP = 1'b1
    } t_action;

    typedef struct packed {
        t_action               action;
        logic [PRIO_W-1:0]     priority_req;
        logic [OUT_PAY_W-1:0]  payload;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [PRIO_W-1:0]     out_priority;
        logic [OUT_PAY_W-1:0]  out_payload;
        logic [REM_W-1:0]      remaining;
    } t_out_item;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_POP    = 3'd1,
        CELL_URGENT = 3'd2,
        CELL_START  = 3'd3,
        CELL_STEP   = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [PRIO_W-1:0]  new_prio;
    } t_cell_cmd;

    typedef enum logic {
        SQ_IDLE  = 1'b0,
        SQ_SHIFT = 1'b1
    } t_seq_state;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell #(
    parameter int DW  = 32,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spq_pkg::t_cell_cmd         i_cmd,
    input  logic [DW-1:0]              i_new_pay,
    input  logic [CW-1:0]              i_count,
    input  logic [spq_pkg::PRIO_W-1:0] i_left_prio,
    input  logic [DW-1:0]              i_left_pay,
    input  logic [spq_pkg::PRIO_W-1:0] i_right_prio,
    input  logic [DW-1:0]              i_right_pay,
    input  logic                       i_right_take,
    output logic [spq_pkg::PRIO_W-1:0] o_prio,
    output logic [DW-1:0]              o_pay,
    output logic                       o_take,
    output logic                       o_place
);

    logic [spq_pkg::PRIO_W-1:0] r_prio;
    logic [spq_pkg::PRIO_W-1:0] n_prio;
    logic [DW-1:0]              r_pay;
    logic [DW-1:0]              n_pay;
    logic                       r_hole;
    logic                       n_hole;
    logic                       w_left_greater;
    logic                       w_step;

    // the front cell has no left neighbour, so the hole always fills there
    assign w_left_greater = (IDX != 0) && (i_left_prio > i_cmd.new_prio);
    assign w_step         = (i_cmd.op == spq_pkg::CELL_STEP) && r_hole;
    assign o_take         = w_step && w_left_greater;
    assign o_place        = w_step && !w_left_greater;
    assign o_prio         = r_prio;
    assign o_pay          = r_pay;

    always_comb begin
        n_prio = r_prio;
        n_pay  = r_pay;
        n_hole = r_hole;
        case (i_cmd.op)
            spq_pkg::CELL_POP: begin
                n_prio = i_right_prio;
                n_pay  = i_right_pay;
                n_hole = 1'b0;
            end
            spq_pkg::CELL_URGENT: begin
                if (IDX == 0) begin
                    n_prio = i_cmd.new_prio;
                    n_pay  = i_new_pay;
                end else begin
                    n_prio = i_left_prio;
                    n_pay  = i_left_pay;
                end
                n_hole = 1'b0;
            end
            spq_pkg::CELL_START: begin
                n_hole = (i_count == CW'(IDX));
            end
            spq_pkg::CELL_STEP: begin
                if (o_take) begin
                    n_prio = i_left_prio;
                    n_pay  = i_left_pay;
                    n_hole = 1'b0;
                end else if (o_place) begin
                    n_prio = i_cmd.new_prio;
                    n_pay  = i_new_pay;
                    n_hole = 1'b0;
                end else if (i_right_take) begin
                    n_hole = 1'b1;
                end
            end
            default: begin
                n_hole = r_hole;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hole <= 1'b0;
        end else begin
            r_hole <= n_hole;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_pay  <= n_pay;
    end

endmodule

FILE: rtl/stable_priority_event_queue_core.sv
// stable priority event queue, a row of DEPTH storage cells with the front at cell 0
// input channel i_in_valid / o_in_stall carries one operation: add an event or pop
// the front event. output channel o_out_valid / i_out_stall carries one result per
// operation: status, popped priority and payload, and the number of events left.
// config channel i_cfg_valid / o_cfg_ready writes the urgent priority value.
// every result is registered and appears the cycle after its transfer.
// a pop, an urgent add, a pop on empty and an add to a full queue leave the queue
// idle, so such operations can follow each other in consecutive cycles while the
// receiver does not stall. a normal add moves a hole from the back of the stored
// events towards the front, one cell per cycle, while each passed cell hands its
// event one place back; the input stalls until the hole has passed every stored
// event that sorts behind the new one and the new event is placed.
// the result of an add is issued at once; the next transfer waits for the hole.
// when the receiver stalls, the result holds and new transfers are stalled until
// the result is taken in the same cycle or earlier.
// reset empties the queue and clears the urgent priority to 0; stored payloads are
// not cleared.
module stable_priority_event_queue_core #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  spq_pkg::t_in_item                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output spq_pkg::t_out_item                 o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [spq_pkg::PRIO_W-1:0]         i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

    spq_pkg::t_seq_state        r_state;
    spq_pkg::t_seq_state        n_state;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [spq_pkg::PRIO_W-1:0] r_urgent;
    logic [spq_pkg::PRIO_W-1:0] r_new_prio;
    logic [DW-1:0]              r_new_pay;
    logic                       r_out_valid;
    spq_pkg::t_out_item         r_out;
    spq_pkg::t_out_item         n_out;

    spq_pkg::t_cell_cmd         w_cmd;
    logic [DW-1:0]              w_new_pay;
    logic                       w_accept;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_is_add;
    logic                       w_urgent;
    logic                       w_done;

    logic [spq_pkg::PRIO_W-1:0] w_prio  [DEPTH];
    logic [DW-1:0]              w_pay   [DEPTH];
    logic [DEPTH-1:0]           w_take;
    logic [DEPTH-1:0]           w_place;

    assign o_in_stall  = (r_state != spq_pkg::SQ_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = (r_state == spq_pkg::SQ_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_is_add = (i_in.action == spq_pkg::ACT_ADD);
    assign w_urgent = (i_in.priority_req == r_urgent);
    assign w_done   = |w_place;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spq_pkg::SQ_IDLE: begin
                if (w_accept && w_is_add && !w_full && !w_urgent) begin
                    n_state = spq_pkg::SQ_SHIFT;
                end
            end
            spq_pkg::SQ_SHIFT: begin
                if (w_done) begin
                    n_state = spq_pkg::SQ_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::SQ_IDLE;
            end
        endcase
    end

    // cell commands
    always_comb begin
        w_cmd.op       = spq_pkg::CELL_HOLD;
        w_cmd.new_prio = r_new_prio;
        w_new_pay      = r_new_pay;
        case (r_state)
            spq_pkg::SQ_IDLE: begin
                w_cmd.new_prio = i_in.priority_req;
                w_new_pay      = i_in.payload[DW-1:0];
                if (w_accept) begin
                    if (w_is_add) begin
                        if (!w_full) begin
                            w_cmd.op = w_urgent ? spq_pkg::CELL_URGENT : spq_pkg::CELL_START;
                        end
                    end else if (!w_empty) begin
                        w_cmd.op = spq_pkg::CELL_POP;
                    end
                end
            end
            spq_pkg::SQ_SHIFT: begin
                w_cmd.op = spq_pkg::CELL_STEP;
            end
            default: begin
                w_cmd.op = spq_pkg::CELL_HOLD;
            end
        endcase
    end

    // count and result
    always_comb begin
        n_count            = r_count;
        n_out.status       = spq_pkg::ST_ADDED;
        n_out.out_priority = '0;
        n_out.out_payload  = '0;
        if (w_is_add) begin
            if (w_full) begin
                n_out.status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (w_empty) begin
            n_out.status = spq_pkg::ST_EMPTY;
        end else begin
            n_count            = r_count - CW'(1);
            n_out.status       = spq_pkg::ST_POPPED;
            n_out.out_priority = w_prio[0];
            n_out.out_payload  = spq_pkg::OUT_PAY_W'(w_pay[0]);
        end
        n_out.remaining = spq_pkg::REM_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::SQ_IDLE;
            r_count     <= '0;
            r_urgent    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_urgent <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out      <= n_out;
            r_new_prio <= i_in.priority_req;
            r_new_pay  <= i_in.payload[DW-1:0];
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [spq_pkg::PRIO_W-1:0] w_lp;
        logic [DW-1:0]              w_lpay;
        logic [spq_pkg::PRIO_W-1:0] w_rp;
        logic [DW-1:0]              w_rpay;
        logic                       w_rtake;

        if (g == 0) begin : g_front
            assign w_lp   = '0;
            assign w_lpay = '0;
        end else begin : g_mid_l
            assign w_lp   = w_prio[g-1];
            assign w_lpay = w_pay[g-1];
        end

        if (g == DEPTH - 1) begin : g_back
            assign w_rp    = '0;
            assign w_rpay  = '0;
            assign w_rtake = 1'b0;
        end else begin : g_mid_r
            assign w_rp    = w_prio[g+1];
            assign w_rpay  = w_pay[g+1];
            assign w_rtake = w_take[g+1];
        end

        spq_cell #(
            .DW  (DW),
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_new_pay    (w_new_pay),
            .i_count      (r_count),
            .i_left_prio  (w_lp),
            .i_left_pay   (w_lpay),
            .i_right_prio (w_rp),
            .i_right_pay  (w_rpay),
            .i_right_take (w_rtake),
            .o_prio       (w_prio[g]),
            .o_pay        (w_pay[g]),
            .o_take       (w_take[g]),
            .o_place      (w_place[g])
        );
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH      = 16;
    localparam int HOLD_LIMIT = 500000;
    localparam int EXP_SLOTS  = 64;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    spq_pkg::t_in_item          i_in;
    logic                       o_out_valid;
    logic                       i_out_stall;
    spq_pkg::t_out_item         o_out;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [spq_pkg::PRIO_W-1:0] i_cfg_data;

    stable_priority_event_queue_core #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (32)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the stored events, front at index 0
    logic [spq_pkg::PRIO_W-1:0]    shadow_prio [DEPTH];
    logic [spq_pkg::OUT_PAY_W-1:0] shadow_pay  [DEPTH];
    int                            shadow_count = 0;
    logic [spq_pkg::PRIO_W-1:0]    urgent_level = '0;

    // expected results in transfer order
    spq_pkg::t_out_item exp_store [EXP_SLOTS];
    int        exp_wr        = 0;
    int        exp_rd        = 0;
    int        exp_level     = 0;
    int        error_count   = 0;
    int        cycle_count   = 0;
    int        send_gap_max  = 13;
    int        recv_gap_max  = 13;
    int        stall_left    = 0;
    int        long_hold     = 0;

    function automatic void result_enqueue(input spq_pkg::t_out_item item);
        exp_store[exp_wr] = item;
        exp_wr = (exp_wr + 1) % EXP_SLOTS;
        exp_level++;
    endfunction

    function automatic spq_pkg::t_out_item result_dequeue();
        spq_pkg::t_out_item item;
        item = exp_store[exp_rd];
        exp_rd = (exp_rd + 1) % EXP_SLOTS;
        exp_level--;
        return item;
    endfunction

    function automatic spq_pkg::t_out_item apply_to_shadow_queue(input spq_pkg::t_in_item op);
        spq_pkg::t_out_item res;
        int                 pos;
        res = '0;
        if (op.action == spq_pkg::ACT_ADD) begin
            if (shadow_count >= DEPTH) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                if (op.priority_req == urgent_level) begin
                    pos = 0;
                end else begin
                    pos = shadow_count;
                    while (pos > 0 && shadow_prio[pos-1] > op.priority_req)
                        pos--;
                end
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_pay[i]  = shadow_pay[i-1];
                end
                shadow_prio[pos] = op.priority_req;
                shadow_pay[pos]  = op.payload;
                shadow_count++;
                res.status = spq_pkg::ST_ADDED;
            end
        end else if (shadow_count == 0) begin
            res.status = spq_pkg::ST_EMPTY;
        end else begin
            res.status       = spq_pkg::ST_POPPED;
            res.out_priority = shadow_prio[0];
            res.out_payload  = shadow_pay[0];
            for (int i = 1; i < shadow_count; i++) begin
                shadow_prio[i-1] = shadow_prio[i];
                shadow_pay[i-1]  = shadow_pay[i];
            end
            shadow_count--;
        end
        res.remaining = spq_pkg::REM_W'(shadow_count);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic send_op(input spq_pkg::t_in_item op);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= op;
        do @(posedge i_clk); while (o_in_stall);
        result_enqueue(apply_to_shadow_queue(op));
    endtask

    function automatic spq_pkg::t_in_item make_op(input spq_pkg::t_action act,
                                                  input logic [7:0] prio,
                                                  input logic [31:0] pay);
        spq_pkg::t_in_item op;
        op.action       = act;
        op.priority_req = prio;
        op.payload      = pay;
        return op;
    endfunction

    function automatic spq_pkg::t_in_item random_op(input int add_pct);
        logic [7:0] prio;
        case ($urandom_range(0, 3))
            0:       prio = urgent_level;
            1:       prio = 8'($urandom_range(0, 7));
            2:       prio = 8'($urandom);
            default: prio = $urandom_range(0, 1) ? 8'hff : 8'($urandom_range(248, 255));
        endcase
        return make_op(($urandom_range(0, 99) < add_pct) ? spq_pkg::ACT_ADD : spq_pkg::ACT_POP,
                       prio, $urandom);
    endfunction

    // idle the input, let every result arrive and the insertion shift finish
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (exp_level != 0) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic write_urgent(input logic [spq_pkg::PRIO_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        urgent_level = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_order();
        write_urgent(8'h00);
        send_op(make_op(spq_pkg::ACT_POP, 8'h00, 32'h0));
        send_op(make_op(spq_pkg::ACT_ADD, 8'hff, 32'hffff_ffff));
        send_op(make_op(spq_pkg::ACT_ADD, 8'h80, 32'h0000_0000));
        send_op(make_op(spq_pkg::ACT_ADD, 8'h80, 32'h0000_0001));
        send_op(make_op(spq_pkg::ACT_ADD, 8'h40, 32'h0000_0002));
        send_op(make_op(spq_pkg::ACT_ADD, 8'h00, 32'ha5a5_a5a5));
        send_op(make_op(spq_pkg::ACT_ADD, 8'h00, 32'h5a5a_5a5a));
        send_op(make_op(spq_pkg::ACT_ADD, 8'hff, 32'h0000_0003));
        repeat (8) send_op(make_op(spq_pkg::ACT_POP, 8'hff, 32'hffff_ffff));
        settle();
        write_urgent(8'hff);
        send_op(make_op(spq_pkg::ACT_ADD, 8'h0a, 32'h1234_5678));
        send_op(make_op(spq_pkg::ACT_ADD, 8'h05, 32'h8765_4321));
        send_op(make_op(spq_pkg::ACT_ADD, 8'hff, 32'hdead_beef));
        send_op(make_op(spq_pkg::ACT_ADD, 8'h03, 32'h0f0f_0f0f));
        repeat (5) send_op(make_op(spq_pkg::ACT_POP, 8'h00, 32'h0));
    endtask

    task automatic test_full_and_empty();
        settle();
        write_urgent(8'($urandom));
        while (shadow_count < DEPTH) send_op(random_op(100));
        repeat (4) send_op(random_op(100));
        while (shadow_count > 0) send_op(random_op(0));
        repeat (2) send_op(random_op(0));
    endtask

    task automatic test_random_traffic();
        int add_pct;
        for (int phase = 0; phase < 5; phase++) begin
            settle();
            case (phase)
                0: begin write_urgent(8'h00); send_gap_max = 0; recv_gap_max = 0;
                         add_pct = 55; end
                1: begin write_urgent(8'hff); send_gap_max = 13; recv_gap_max = 13;
                         add_pct = 60; end
                2: begin write_urgent(8'($urandom)); send_gap_max = 0; recv_gap_max = 13;
                         add_pct = 70; end
                3: begin write_urgent(8'($urandom)); send_gap_max = 13; recv_gap_max = 0;
                         add_pct = 40; end
                default: begin write_urgent(8'h80); send_gap_max = 5; recv_gap_max = 5;
                               add_pct = 55; end
            endcase
            repeat (250) send_op(random_op(add_pct));
        end
        send_gap_max = 13;
        recv_gap_max = 13;
    endtask

    task automatic test_backpressure();
        settle();
        write_urgent(8'($urandom));
        send_gap_max = 0;
        for (int burst = 0; burst < 2; burst++) begin
            long_hold = 80;
            repeat (40) send_op(random_op(65));
            // sender waits for every transfer to come back before the next burst
            settle();
        end
        send_gap_max = 13;
    endtask

    // receiving side
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold > 0) begin
                long_hold--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        spq_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_level == 0) begin
                report_mismatch("transfer with nothing outstanding, status",
                                32'(o_out.status), 32'(0));
            end else begin
                want = result_dequeue();
                if (o_out.status !== want.status)
                    report_mismatch("status", 32'(o_out.status), 32'(want.status));
                if (o_out.out_priority !== want.out_priority)
                    report_mismatch("priority", 32'(o_out.out_priority),
                                    32'(want.out_priority));
                if (o_out.out_payload !== want.out_payload)
                    report_mismatch("payload", o_out.out_payload, want.out_payload);
                if (o_out.remaining !== want.remaining)
                    report_mismatch("remaining", 32'(o_out.remaining), 32'(want.remaining));
            end
            stall_left = $urandom_range(0, recv_gap_max);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > HOLD_LIMIT) begin
            $display("** stable_priority_event_queue_core: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_order();
        test_full_and_empty();
        test_random_traffic();
        test_backpressure();
        settle();
        if (exp_level != 0)
            report_mismatch("results never arrived", 32'(exp_level), 32'(0));
        if (error_count == 0) begin
            $display("** stable_priority_event_queue_core: PASSED **");
        end else begin
            $display("** stable_priority_event_queue_core: FAILED **");
        end
        $finish;
    end

endmodule
